@@ rtl/core/rtda_pkg.sv @@
// ----------------------------------------------------------------------------
// rtda_pkg
// Shared types and constants of the top-down range allocator.
// ----------------------------------------------------------------------------
package rtda_pkg;

  localparam int unsigned VAL_W = 53;
  localparam int unsigned TOT_W = 64;
  localparam int unsigned ST_W  = 3;
  localparam int unsigned OP_W  = 2;

  // width of the physical address space
  localparam int unsigned ADDR_BITS = 52;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd2;
  localparam logic [OP_W-1:0] OP_SEAL  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK     = 3'd0;
  localparam logic [ST_W-1:0] ST_NOFIT  = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 3'd2;
  localparam logic [ST_W-1:0] ST_SEALED = 3'd3;
  localparam logic [ST_W-1:0] ST_ZERO   = 3'd4;

  localparam logic [VAL_W-1:0] LOW_FLOOR = 53'd1 << 20;
  localparam logic [VAL_W-1:0] ADDR_TOP  = 53'd1 << ADDR_BITS;

  // one range as it travels through the chain
  typedef struct packed {
    logic             vld;
    logic [VAL_W-1:0] rstart;
    logic [VAL_W-1:0] rend;
  } range_t;

endpackage

@@ rtl/core/rtda_cell.sv @@
// ----------------------------------------------------------------------------
// rtda_cell
// One slot of the range chain: holds a range and shifts it to its neighbor.
// ----------------------------------------------------------------------------
module rtda_cell (
  input  logic              clk_i,
  input  logic              shift_i,
  input  logic              load_i,
  input  rtda_pkg::range_t  nbr_i,
  input  rtda_pkg::range_t  load_val_i,
  output rtda_pkg::range_t  slot_o
);

  rtda_pkg::range_t slot_q, slot_d;

  // load wins over shift; otherwise hold
  always_comb begin
    slot_d = slot_q;
    if (load_i) begin
      slot_d = load_val_i;
    end else if (shift_i) begin
      slot_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;

endmodule

@@ rtl/core/range_table_top_down_allocator.sv @@
// ----------------------------------------------------------------------------
// range_table_top_down_allocator
// Top-down physical range allocator with a rotating chain of range cells.
// ----------------------------------------------------------------------------
// Clear, seal and add items go from idle straight to the output state. An
// allocate item rotates the whole chain of MAX_RANGES cells once, then fixes
// up the table: the head cell is examined each cycle from index 0 up, and a
// later fit wins; the rest rotate past unchanged. The chain is a ring:
// slot 0 is the head, and index k of the table lives at slot k while idle.
// One item is worked on at a time; the result sits in an output register.
module range_table_top_down_allocator #(
  parameter int unsigned MAX_RANGES = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [52:0]  cfg_wdata_i,      // upper_limit
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // operation[1:0], region_base[53:2], region_length[106:54],
  // region_usable[107], alloc_size[160:108], align_log2[166:161], zero fill
  input  logic [167:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], alloc_address[54:3], allocated_total[118:55],
  // ranges_in_use[127:119]
  output logic [127:0] m_axis_tdata
);

  localparam int unsigned CW = $clog2(MAX_RANGES + 1);
  localparam int unsigned IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned VW = rtda_pkg::VAL_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROT  = 3'd1;
  localparam logic [2:0] S_FIX  = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;

  logic [2:0]  state_q, state_d;
  logic [52:0] limit_q;
  logic [CW-1:0] count_q, count_d;
  logic [63:0] total_q, total_d;
  logic        sealed_q, sealed_d;

  // latched item
  logic [1:0]    op_q;
  logic [VW-1:0] size_q;
  logic [5:0]    lg_q;
  logic [CW-1:0] rot_q, rot_d;       // rotations done
  logic          found_q, found_d;
  logic [IW-1:0] hit_q, hit_d;
  logic [VW-1:0] top_q, top_d;
  logic [VW-1:0] hend_q, hend_d;
  logic [VW-1:0] hs_q, hs_d;         // start of the chosen range
  logic [2:0]    st_q, st_d;
  logic [51:0]   addr_q, addr_d;

  // copy of the last table entry
  logic [VW-1:0] last_s_q, last_s_d;
  logic [VW-1:0] last_e_q, last_e_d;

  logic          out_vld_q;
  logic [127:0]  out_q;

  rtda_pkg::range_t slot   [MAX_RANGES];
  logic             shift;
  logic [MAX_RANGES-1:0] load;
  rtda_pkg::range_t lval   [MAX_RANGES];

  // chain of cells, rotating toward lower slots
  for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
    rtda_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (shift),
      .load_i     (load[g]),
      .nbr_i      (slot[(g + 1) % MAX_RANGES]),
      .load_val_i (lval[g]),
      .slot_o     (slot[g])
    );
  end

  // input field decode
  logic [1:0]    in_op;
  logic [51:0]   in_base;
  logic [52:0]   in_len;
  logic          in_use;
  logic [52:0]   in_size;
  logic [5:0]    in_lg;
  assign in_op   = s_axis_tdata[1:0];
  assign in_base = s_axis_tdata[53:2];
  assign in_len  = s_axis_tdata[106:54];
  assign in_use  = s_axis_tdata[107];
  assign in_size = s_axis_tdata[160:108];
  assign in_lg   = s_axis_tdata[166:161];

  logic accept;
  assign s_axis_tready = (state_q == S_IDLE) && !out_vld_q;
  assign accept = s_axis_tvalid && s_axis_tready;

  // add path: clip and merge with the last entry, kept in a copy register
  logic [VW:0]   add_hi_raw;
  logic [VW-1:0] eff_lim, add_lo, add_hi;
  logic          add_empty, add_merge;
  logic [IW-1:0] last_idx, cnt_idx;
  assign eff_lim = (limit_q > rtda_pkg::ADDR_TOP) ? rtda_pkg::ADDR_TOP : limit_q;
  assign add_hi_raw = {1'b0, 1'b0, in_base} + {1'b0, in_len};
  assign add_lo = ({1'b0, in_base} < rtda_pkg::LOW_FLOOR) ? rtda_pkg::LOW_FLOOR
                                                          : {1'b0, in_base};
  assign add_hi = (add_hi_raw > {1'b0, eff_lim}) ? eff_lim : add_hi_raw[VW-1:0];
  assign add_empty = add_lo >= add_hi;
  assign last_idx = IW'(count_q - CW'(1));
  assign cnt_idx  = IW'(count_q);
  assign add_merge = (count_q != '0) && (last_e_q == add_lo);

  // allocate probe of the head cell
  logic [CW-1:0] hd_k;               // table index now at the head
  logic [VW-1:0] amask, fit_top;
  logic [VW-1:0] h_s, h_e;
  logic          h_fit;
  assign h_s = slot[0].rstart;
  assign h_e = slot[0].rend;
  assign amask = (lg_q >= 6'(VW)) ? '0 : ~((VW'(1) << lg_q) - VW'(1));
  assign fit_top = (h_e - size_q) & amask;
  assign hd_k = rot_q;
  assign h_fit = (h_e >= h_s) && ((h_e - h_s) >= size_q) && (fit_top >= h_s);

  // sequencer
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    total_d  = total_q;
    sealed_d = sealed_q;
    rot_d    = rot_q;
    found_d  = found_q;
    hit_d    = hit_q;
    top_d    = top_q;
    hend_d   = hend_q;
    hs_d     = hs_q;
    st_d     = st_q;
    addr_d   = addr_q;
    last_s_d = last_s_q;
    last_e_d = last_e_q;
    shift    = 1'b0;
    load     = '0;
    for (int i = 0; i < MAX_RANGES; i++) begin
      lval[i] = '0;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          st_d   = rtda_pkg::ST_OK;
          addr_d = '0;
          found_d = 1'b0;
          rot_d  = '0;
          state_d = S_OUT;
          case (in_op)
            rtda_pkg::OP_CLEAR: begin
              count_d = '0;
              total_d = '0;
              sealed_d = 1'b0;
            end
            rtda_pkg::OP_ADD: begin
              if (in_use && !add_empty) begin
                if (add_merge) begin
                  load[last_idx] = 1'b1;
                  lval[last_idx] = '{vld: 1'b1, rstart: last_s_q, rend: add_hi};
                  last_e_d = add_hi;
                end else if (count_q >= CW'(MAX_RANGES)) begin
                  st_d = rtda_pkg::ST_FULL;
                end else begin
                  load[cnt_idx] = 1'b1;
                  lval[cnt_idx] = '{vld: 1'b1, rstart: add_lo, rend: add_hi};
                  count_d = count_q + CW'(1);
                  last_s_d = add_lo;
                  last_e_d = add_hi;
                end
              end
            end
            rtda_pkg::OP_ALLOC: begin
              if (sealed_q) begin
                st_d = rtda_pkg::ST_SEALED;
              end else if (in_size == '0) begin
                st_d = rtda_pkg::ST_ZERO;
              end else begin
                state_d = S_ROT;
              end
            end
            default: sealed_d = 1'b1;
          endcase
        end
      end
      S_ROT: begin
        // head holds table index rot_q; later hits (higher index) win
        if ((hd_k < count_q) && h_fit) begin
          found_d = 1'b1;
          hit_d   = IW'(hd_k);
          top_d   = fit_top;
          hend_d  = h_e;
          hs_d    = h_s;
        end
        shift = 1'b1;
        rot_d = rot_q + CW'(1);
        if (rot_q == CW'(MAX_RANGES - 1)) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        state_d = S_OUT;
        if (!found_q) begin
          st_d = rtda_pkg::ST_NOFIT;
        end else if ((top_q + size_q < hend_q) && (count_q >= CW'(MAX_RANGES))) begin
          st_d = rtda_pkg::ST_FULL;
        end else begin
          load[hit_q] = 1'b1;
          lval[hit_q] = '{vld: 1'b1, rstart: hs_q, rend: top_q};
          if (hit_q == last_idx) begin
            last_e_d = top_q;
          end
          if (top_q + size_q < hend_q) begin
            load[cnt_idx] = 1'b1;
            lval[cnt_idx] = '{vld: 1'b1, rstart: top_q + size_q, rend: hend_q};
            count_d = count_q + CW'(1);
            last_s_d = top_q + size_q;
            last_e_d = hend_q;
          end
          total_d = total_q + 64'(size_q);
          addr_d  = top_q[51:0];
        end
      end
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      limit_q   <= 53'd1 << 52;
      count_q   <= '0;
      total_q   <= '0;
      sealed_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      total_q  <= total_d;
      sealed_q <= sealed_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (state_q == S_OUT) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    rot_q    <= rot_d;
    found_q  <= found_d;
    hit_q    <= hit_d;
    top_q    <= top_d;
    hend_q   <= hend_d;
    hs_q     <= hs_d;
    st_q     <= st_d;
    addr_q   <= addr_d;
    last_s_q <= last_s_d;
    last_e_q <= last_e_d;
    if (accept) begin
      op_q   <= in_op;
      size_q <= in_size;
      lg_q   <= in_lg;
    end
    if (state_q == S_OUT) begin
      out_q <= {9'(count_q), total_q, addr_q, st_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // the chain only rotates during an allocate
  a_rot_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROT) |-> (op_q == rtda_pkg::OP_ALLOC))
    else $error("rotation outside allocate");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_RANGES))
    else $error("range count over capacity");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready)
    else $error("accept while busy");
  a_total_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIX && total_d != total_q) |=> (st_q == rtda_pkg::ST_OK))
    else $error("total changed on failed allocate");

endmodule

@@ tb/sv/range_alloc_scoreboard.sv @@
// ----------------------------------------------------------------------------
// range_alloc_scoreboard
// Watches the item streams of the range allocator and the limit register.
// It keeps its own range table, works out the result of every accepted
// item and compares each returned result with the oldest one outstanding.
// ----------------------------------------------------------------------------
module range_alloc_scoreboard (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [52:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [167:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [127:0] m_axis_tdata,
  output int           errors_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam logic [63:0] ADDR_TOP    = 64'd1 << 52;
  localparam logic [63:0] FLOOR       = 64'd1 << 20;

  // laid out as on the result bus, status in the lowest bits
  typedef struct packed {
    logic [8:0]  count;
    logic [63:0] total;
    logic [51:0] addr;
    logic [2:0]  status;
  } alloc_result_t;

  // shadow of the allocator state
  logic [63:0]   free_lo [TABLE_DEPTH];
  logic [63:0]   free_hi [TABLE_DEPTH];
  int unsigned   n_ranges;
  logic [63:0]   total_bytes;
  logic          is_sealed;
  logic [63:0]   top_limit;
  alloc_result_t awaited_results[$];

  // add one map entry, clipped to the usable window
  function automatic logic [2:0] add_entry(logic [63:0] base, logic [63:0] len,
                                           logic usable);
    logic [63:0] lo, hi, lim;
    if (!usable) return rtda_pkg::ST_OK;
    lo  = base;
    hi  = base + len;
    lim = (top_limit > ADDR_TOP) ? ADDR_TOP : top_limit;
    if (lo < FLOOR) lo = FLOOR;
    if (hi > lim) hi = lim;
    if (lo >= hi) return rtda_pkg::ST_OK;
    if (n_ranges > 0 && free_hi[n_ranges-1] == lo) begin
      free_hi[n_ranges-1] = hi;
      return rtda_pkg::ST_OK;
    end
    if (n_ranges >= TABLE_DEPTH) return rtda_pkg::ST_FULL;
    free_lo[n_ranges] = lo;
    free_hi[n_ranges] = hi;
    n_ranges++;
    return rtda_pkg::ST_OK;
  endfunction

  // top-down search for the highest aligned block that fits
  function automatic logic [2:0] carve_block(logic [63:0] size, logic [5:0] lg,
                                             output logic [63:0] addr);
    logic [63:0] amask, s, e, top, stop;
    addr  = '0;
    amask = ~((64'd1 << lg) - 64'd1);
    if (is_sealed) return rtda_pkg::ST_SEALED;
    if (size == 0) return rtda_pkg::ST_ZERO;
    for (int i = int'(n_ranges) - 1; i >= 0; i--) begin
      s = free_lo[i];
      e = free_hi[i];
      if (e < s || e - s < size) continue;
      top = (e - size) & amask;
      if (top < s) continue;
      stop = top + size;
      if (stop < e) begin
        if (n_ranges >= TABLE_DEPTH) return rtda_pkg::ST_FULL;
        free_lo[n_ranges] = stop;
        free_hi[n_ranges] = e;
        n_ranges++;
      end
      free_hi[i] = top;
      total_bytes += size;
      addr = top;
      return rtda_pkg::ST_OK;
    end
    return rtda_pkg::ST_NOFIT;
  endfunction

  function automatic alloc_result_t predict_result(logic [167:0] d);
    alloc_result_t r;
    logic [63:0]   addr;
    logic [2:0]    st;
    st   = rtda_pkg::ST_OK;
    addr = '0;
    case (d[1:0])
      rtda_pkg::OP_CLEAR: begin
        n_ranges    = 0;
        total_bytes = '0;
        is_sealed   = 1'b0;
      end
      rtda_pkg::OP_ADD:
        st = add_entry({12'd0, d[53:2]}, {11'd0, d[106:54]}, d[107]);
      rtda_pkg::OP_ALLOC:
        st = carve_block({11'd0, d[160:108]}, d[166:161], addr);
      default:  is_sealed = 1'b1;
    endcase
    if (st != rtda_pkg::ST_OK) addr = '0;
    r.status = st;
    r.addr   = addr[51:0];
    r.total  = total_bytes;
    r.count  = n_ranges[8:0];
    return r;
  endfunction

  // sample both streams and the register port at every edge
  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t want, got;
    if (!rst_ni) begin
      n_ranges    = 0;
      total_bytes = '0;
      is_sealed   = 1'b0;
      top_limit   = ADDR_TOP;
      errors_o    = 0;
      awaited_results.delete();
      pending_o   = 0;
    end else begin
      if (cfg_we_i) top_limit = {11'd0, cfg_wdata_i};
      if (s_axis_tvalid && s_axis_tready)
        awaited_results.push_back(predict_result(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (awaited_results.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("unexpected result item %h", got);
        end else begin
          want = awaited_results.pop_front();
          if (want != got) begin
            errors_o++;
            if (errors_o <= 10)
              $display("mismatch: status %0d/%0d addr %h/%h total %h/%h count %0d/%0d",
                       want.status, got.status, want.addr, got.addr,
                       want.total, got.total, want.count, got.count);
          end
        end
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

@@ tb/sv/tb_range_table_top_down_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_range_table_top_down_allocator
// Drives directed and random clear, add, allocate and seal items into the
// range allocator under several limit settings, with random gaps on both
// streams and one long output stall; the scoreboard checks every result.
// ----------------------------------------------------------------------------
module tb_range_table_top_down_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_WAIT  = 300;
  localparam logic [52:0] LIM_RESET   = 53'd1 << 52;
  localparam logic [52:0] LIM_MAX     = '1;
  localparam logic [63:0] MIB         = 64'd1 << 20;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [52:0]  cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;
  int           errors;
  int           pending;
  logic         calm;
  logic         rx_hold;
  logic         hold_go;
  int           rx_gap;
  logic [63:0]  next_base;

  range_table_top_down_allocator DUT (.*);

  range_alloc_scoreboard u_scoreboard (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .errors_o(errors), .pending_o(pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_range_table_top_down_allocator: errors");
    $finish;
  end

  // long output stall while items keep coming
  initial begin
    rx_hold = 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (3000) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // result side with random gaps
  initial begin
    m_axis_tready = 1'b0;
    rx_gap        = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) rx_gap = calm ? 0 : $urandom_range(0, 9);
      else if (rx_gap > 0) rx_gap--;
      m_axis_tready <= rst_ni && (rx_gap == 0) && !rx_hold;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // random value of up to the given number of bits
  function automatic logic [63:0] rand_bits(int unsigned nbits);
    return rand64() & ((64'd1 << nbits) - 64'd1);
  endfunction

  task automatic send_item(logic [1:0] op, logic [63:0] base, logic [63:0] len,
                           logic usable, logic [63:0] size, logic [5:0] align);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, align, size[52:0], usable, len[52:0], base[51:0], op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic push_region(logic [63:0] base, logic [63:0] len);
    send_item(rtda_pkg::OP_ADD, base, len, 1'b1, rand64(), 6'($urandom));
  endtask

  task automatic alloc_bytes(logic [63:0] size, logic [5:0] align);
    send_item(rtda_pkg::OP_ALLOC, rand64(), rand64(), 1'($urandom), size, align);
  endtask

  task automatic plain_op(logic [1:0] op);
    send_item(op, rand64(), rand64(), 1'($urandom), rand64(), 6'($urandom));
  endtask

  // limit writes happen only once the block has gone quiet
  task automatic set_limit(logic [52:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_item();
    int unsigned pick;
    logic [63:0] base, len;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      plain_op(rtda_pkg::OP_CLEAR);
      next_base = MIB;
    end else if (pick < 6) begin
      plain_op(rtda_pkg::OP_SEAL);
    end else if (pick < 50) begin
      case ($urandom_range(0, 4))
        0:       base = rand_bits(52);
        1:       base = rand_bits(20);
        2:       base = next_base + rand_bits($urandom_range(0, 24));
        default: base = next_base;
      endcase
      len = ($urandom_range(0, 9) == 0) ? rand_bits(53)
                                        : rand_bits($urandom_range(0, 40));
      next_base = base + len;
      send_item(rtda_pkg::OP_ADD, base, len, $urandom_range(0, 7) != 0, rand64(),
                6'($urandom));
    end else begin
      alloc_bytes(($urandom_range(0, 19) == 0) ? rand_bits(53)
                    : rand_bits($urandom_range(0, 36)),
                  ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                    : 6'($urandom_range(0, 24)));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    calm          = 1'b0;
    hold_go       = 1'b0;
    next_base     = MIB;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_limit(LIM_RESET);

    // directed: error cases, clipping, merge, sizes, seal and clear
    alloc_bytes(64'd1, 6'd0);
    alloc_bytes(64'd0, 6'd0);
    send_item(rtda_pkg::OP_ADD, 64'd2 * MIB, MIB, 1'b0, '0, '0);
    push_region(64'd0, MIB / 2);
    push_region(64'd0, 64'd4 * MIB);
    push_region(64'd4 * MIB, 64'd4 * MIB);
    push_region(64'd16 * MIB, 64'd16 * MIB);
    push_region({12'd0, {52{1'b1}}}, {11'd0, {53{1'b1}}});
    alloc_bytes(64'd1, 6'd0);
    alloc_bytes(64'd4096, 6'd12);
    alloc_bytes(64'd1, 6'd63);
    alloc_bytes({11'd0, {53{1'b1}}}, 6'd0);
    alloc_bytes(MIB, 6'd20);
    alloc_bytes(64'd3 * MIB, 6'd52);
    plain_op(rtda_pkg::OP_SEAL);
    alloc_bytes(64'd16, 6'd4);
    push_region(64'd64 * MIB, MIB);
    plain_op(rtda_pkg::OP_CLEAR);
    push_region(MIB, 64'd8 * MIB);
    alloc_bytes(64'd8 * MIB, 6'd0);
    alloc_bytes(64'd1, 6'd0);

    // limit below the floor drops every entry
    set_limit('0);
    push_region(64'd0, 64'd64 * MIB);
    alloc_bytes(64'd1, 6'd0);

    // limit above the address space acts as the address space
    set_limit(LIM_MAX);
    push_region({12'd0, {52{1'b1}}} - MIB, 64'd4 * MIB);
    alloc_bytes(MIB, 6'd20);

    // full table: no append, merge still works, split refused
    plain_op(rtda_pkg::OP_CLEAR);
    calm = 1'b1;
    for (int i = 0; i < 256; i++) push_region(64'(2 * i + 2) * MIB, MIB);
    calm = 1'b0;
    push_region(64'd1024 * MIB, MIB);
    push_region(64'd513 * MIB, MIB);
    alloc_bytes(64'd1, 6'd0);
    alloc_bytes(64'd1, 6'd12);
    plain_op(rtda_pkg::OP_CLEAR);

    // random part with a few limit settings and one long output stall
    for (int chunk = 0; chunk < 9; chunk++) begin
      case (chunk)
        2:       set_limit('0);
        4:       set_limit(LIM_MAX);
        6:       set_limit(53'($urandom_range(1, 1 << 20)) << $urandom_range(0, 32));
        8:       set_limit(LIM_RESET);
        default: ;
      endcase
      calm = (chunk % 4 == 3);
      if (chunk == 1) hold_go = 1'b1;
      for (int n = 0; n < 18; n++) random_item();
    end

    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_range_table_top_down_allocator: clean");
    end else begin
      $display("tb_range_table_top_down_allocator: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/rtda_pkg.sv
rtl/core/rtda_cell.sv
rtl/core/range_table_top_down_allocator.sv
tb/sv/range_alloc_scoreboard.sv
tb/sv/tb_range_table_top_down_allocator.sv
